### design/deq_pkg.sv
`default_nettype none

package deq_pkg;

  typedef enum logic [2:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_POP_BACK   = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_LIST       = 3'd4
  } cmd_t;

  typedef logic [1:0] status_t;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

  localparam int OUT_DATA_W = 32;
  localparam int OCC_W      = 6;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_LIST_RD
  } state_t;

endpackage

`default_nettype wire

### design/double_ended_queue.sv
`default_nettype none

// Bounded double-ended queue held in a single ring store with a front index
// and an entry count. Every command transfer gives at least one result transfer;
// a result is held in an output register, so a new command is taken while the
// previous result is being drained. Pushes, rejected pushes, empty pops and
// unused codes load their result into the output register as the command is
// taken. A pop reads the store, which has one registered read port, and the
// record is then loaded into the output register from the fetch state.
// A list of N entries does one read then one result per entry and holds off
// further commands until its last result is loaded; on an empty queue it gives
// one empty result. Result-side stalls delay results. Store contents are not cleared by reset.
module double_ended_queue #(
  parameter int DEPTH      = 32,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [2:0]               in_cmd,
  input  wire logic [31:0]              in_entry_data,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output deq_pkg::status_t              out_status,
  output logic [deq_pkg::OUT_DATA_W-1:0] out_data,
  output logic [deq_pkg::OCC_W-1:0]     out_occupancy,
  output logic                          out_last
);

  import deq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  state_t          state_r, state_nxt;
  logic [AW-1:0]   front_r, front_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   idx_r, idx_nxt;
  logic            is_list_r, is_list_nxt;

  logic            out_valid_r, out_valid_nxt;
  status_t         out_status_r, out_status_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic [OCC_W-1:0] out_occ_r, out_occ_nxt;
  logic            out_last_r, out_last_nxt;

  logic                  wr_en, rd_en;
  logic [AW-1:0]         wr_addr, rd_addr;
  logic [DATA_WIDTH-1:0] wr_data, rd_data;

  logic out_free, in_fire, full, empty, fetch_last;
  cmd_t cmd;

  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a, input logic [CW-1:0] b);
    logic [CW:0] s;
    s = (CW+1)'(a) + (CW+1)'(b);
    if (s >= (CW+1)'(DEPTH)) begin
      s = s - (CW+1)'(DEPTH);
    end
    return AW'(s);
  endfunction

  deq_mem #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_free   = !out_valid_r || !out_stall;
  assign in_stall   = !((state_r == S_IDLE) && out_free);
  assign in_fire    = in_valid && !in_stall;
  assign full       = (count_r == CW'(DEPTH));
  assign empty      = (count_r == '0);
  assign cmd        = cmd_t'(in_cmd);
  assign wr_data    = DATA_WIDTH'(in_entry_data);
  assign fetch_last = !is_list_r || ((idx_r + CW'(1)) == count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    is_list_r    <= is_list_nxt;
    out_status_r <= out_status_nxt;
    out_data_r   <= out_data_nxt;
    out_occ_r    <= out_occ_nxt;
    out_last_r   <= out_last_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    front_nxt      = front_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    is_list_nxt    = is_list_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_data_nxt   = out_data_r;
    out_occ_nxt    = out_occ_r;
    out_last_nxt   = out_last_r;
    wr_en          = 1'b0;
    wr_addr        = ring_add(front_r, count_r);
    rd_en          = 1'b0;
    rd_addr        = front_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          out_data_nxt = '0;
          out_last_nxt = 1'b1;
          case (cmd)
            CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
              out_valid_nxt = 1'b1;
              if (full) begin
                out_status_nxt = ST_FULL;
                out_occ_nxt    = OCC_W'(count_r);
              end else begin
                wr_en = 1'b1;
                if (cmd == CMD_PUSH_FRONT) begin
                  front_nxt = ring_add(front_r, CW'(DEPTH - 1));
                  wr_addr   = front_nxt;
                end
                count_nxt      = count_r + CW'(1);
                out_status_nxt = ST_OK;
                out_occ_nxt    = OCC_W'(count_nxt);
              end
            end
            CMD_POP_BACK, CMD_POP_FRONT: begin
              if (empty) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_EMPTY;
                out_occ_nxt    = '0;
              end else begin
                rd_en     = 1'b1;
                count_nxt = count_r - CW'(1);
                if (cmd == CMD_POP_BACK) begin
                  rd_addr = ring_add(front_r, count_nxt);
                end else begin
                  front_nxt = ring_add(front_r, CW'(1));
                end
                is_list_nxt = 1'b0;
                state_nxt   = S_FETCH;
              end
            end
            CMD_LIST: begin
              if (empty) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_EMPTY;
                out_occ_nxt    = '0;
              end else begin
                rd_en       = 1'b1;
                idx_nxt     = '0;
                is_list_nxt = 1'b1;
                state_nxt   = S_FETCH;
              end
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_OK;
              out_occ_nxt    = OCC_W'(count_r);
            end
          endcase
        end
      end
      S_FETCH: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_data_nxt   = OUT_DATA_W'(rd_data);
          out_occ_nxt    = OCC_W'(count_r);
          out_last_nxt   = fetch_last;
          if (fetch_last) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + CW'(1);
            state_nxt = S_LIST_RD;
          end
        end
      end
      S_LIST_RD: begin
        rd_en     = 1'b1;
        rd_addr   = ring_add(front_r, idx_r);
        state_nxt = S_FETCH;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_data      = out_data_r;
  assign out_occupancy = out_occ_r;
  assign out_last      = out_last_r;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count beyond depth");

  a_front_bound: assert property (@(posedge clk) disable iff (!rst_n)
    front_r < AW'(DEPTH - 1) || front_r == AW'(DEPTH - 1))
    else $error("front index beyond depth");

  a_fetch_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |=> state_r == S_FETCH)
    else $error("store read not followed by fetch");

  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !full && (cmd == CMD_PUSH_BACK || cmd == CMD_PUSH_FRONT)
    |=> count_r == $past(count_r) + CW'(1))
    else $error("push did not grow the queue");

  a_list_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> in_stall)
    else $error("command taken during store walk");
`endif

endmodule

`default_nettype wire

### design/deq_mem.sv
`default_nettype none

module deq_mem #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire
